@@ design/dlt_pkg.sv @@
// Package: lease table types, codes and helper functions.
`timescale 1ns / 1ps
package dlt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int KEY_BYTES = 8;
	localparam logic [31:0] LEASE_SEC_DEF = 32'd86400;
	localparam logic [31:0] GRACE_SEC_DEF = 32'd0;

	localparam logic [2:0] FN_DISCOVER = 3'd0;
	localparam logic [2:0] FN_REQUEST = 3'd1;
	localparam logic [2:0] FN_RELEASE = 3'd2;
	localparam logic [2:0] FN_DECLINE = 3'd3;
	localparam logic [2:0] FN_INFORM = 3'd4;

	localparam logic [1:0] RPL_NONE = 2'd0;
	localparam logic [1:0] RPL_OFFER = 2'd1;
	localparam logic [1:0] RPL_ACK = 2'd2;

	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_EXHAUSTED = 3'd1;
	localparam logic [2:0] STS_TABLE_FULL = 3'd2;
	localparam logic [2:0] STS_UNKNOWN = 3'd3;
	localparam logic [2:0] STS_OTHER_SERVER = 3'd4;
	localparam logic [2:0] STS_MISMATCH = 3'd5;
	localparam logic [2:0] STS_BAD_OPTION = 3'd6;

	localparam logic [2:0] CFG_POOL_FIRST = 3'd0;
	localparam logic [2:0] CFG_POOL_LAST = 3'd1;
	localparam logic [2:0] CFG_SERVER = 3'd2;
	localparam logic [2:0] CFG_LEASE = 3'd3;
	localparam logic [2:0] CFG_GRACE = 3'd4;

	localparam logic [7:0] OPT_ADDR_LEN = 8'd4;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] client_key;
		logic [3:0]  key_len;
		logic [31:0] now_seconds;
		logic        has_server_id;
		logic [7:0]  server_id_len;
		logic [31:0] server_id;
		logic        has_requested_ip;
		logic [7:0]  requested_ip_len;
		logic [31:0] requested_ip;
	} req_t;

	typedef struct packed {
		logic [1:0]  reply;
		logic [31:0] your_addr;
		logic [31:0] lease_time;
		logic [2:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [63:0] key;
		logic [3:0]  key_len;
		logic [31:0] addr;
		logic        committed;
		logic [31:0] granted_at;
		logic [31:0] expires_at;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CSCAN,
		ST_DECIDE,
		ST_DIV,
		ST_HSCAN,
		ST_FREE,
		ST_WRITE,
		ST_DONE
	} state_t;

	function automatic logic [63:0] key_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < len) begin
				m[8*b +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

@@ design/dhcp_lease_table_core.sv @@
// Lease table core: client lookup, pool scan with eviction, lease commit and removal.
// An unknown function or bad key length goes straight to done; other requests first scan the
// table for the client (N = TABLE_ENTRIES) and then write the table where needed.
// Decline and a new client on discover add a bit-serial remainder step; a new client also
// takes up to min(pool, N+1) holder scans over the table and a free-slot scan of up
// to N entries. One request at a time; busy stays high until done; results cannot stall.
// Reset clears all valid bits, the host offset and the registers to their defaults.
`timescale 1ns / 1ps
module dhcp_lease_table_core #(
	parameter int TABLE_ENTRIES = dlt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [31:0]   cfg_wdata,
	input  logic          start,
	input  dlt_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output dlt_pkg::rsp_t rsp
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TW = $clog2(TABLE_ENTRIES + 2);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
	localparam logic [32:0] TRY_CAP = 33'(TABLE_ENTRIES + 1);

	dlt_pkg::state_t state_q, state_d;

	logic [31:0] first_q, last_q, server_q, lease_q, grace_q;
	dlt_pkg::req_t req_q;
	logic [63:0] key_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0] offset_q, off_q, cand_q;

	dlt_pkg::entry_t mem [TABLE_ENTRIES];
	dlt_pkg::entry_t mem_rd_s1;
	logic mem_we;

	logic [IW-1:0] scan_idx_q, chk_idx_s1, hit_idx_q, wr_idx_q;
	logic iss_q, chk_vld_s1, hit_q, ins_q, dcl_q;
	dlt_pkg::entry_t hit_ent_q, wr_ent_q;
	logic [32:0] rem_q, dvd_q;
	logic [5:0] div_cnt_q;
	logic [TW-1:0] tries_q;
	dlt_pkg::rsp_t rsp_q;

	logic accept, bad_len, func_bad;
	logic [32:0] pool_size, tries_max, off_inc, rem_next;
	logic [33:0] rem_sh;
	logic [31:0] cand, off_next;
	logic chk_valid, cli_hit, hold_hit, chk_last, cscan_end, hscan_end;
	logic expired, h_found, tries_last, div_last, free_hit, free_last;
	logic rq_commit, rq_refresh;
	logic [2:0] rq_status;
	dlt_pkg::entry_t dec_ent;
	dlt_pkg::rsp_t dec_rsp;
	logic dec_dcl;

	assign accept = start && !busy;
	assign func_bad = req.func > dlt_pkg::FN_INFORM;
	assign bad_len = (req.key_len == 4'd0) || (req.key_len > 4'(dlt_pkg::KEY_BYTES));

	assign pool_size = {1'b0, last_q - first_q} + 33'd1;
	assign tries_max = (pool_size < TRY_CAP) ? pool_size : TRY_CAP;
	assign cand = first_q + off_q;
	assign off_inc = {1'b0, off_q} + 33'd1;
	assign off_next = (off_inc == pool_size) ? 32'd0 : off_inc[31:0];

	assign chk_valid = chk_vld_s1 && valid_q[chk_idx_s1];
	assign cli_hit = chk_valid && (mem_rd_s1.key_len == req_q.key_len) && (mem_rd_s1.key == key_q);
	assign hold_hit = chk_valid && (mem_rd_s1.addr == cand);
	assign chk_last = chk_vld_s1 && (chk_idx_s1 == LAST_IDX);
	assign cscan_end = cli_hit || chk_last;
	assign hscan_end = hold_hit || chk_last;
	assign expired = {1'b0, req_q.now_seconds} > ({1'b0, mem_rd_s1.expires_at} + {1'b0, grace_q});
	assign h_found = !hold_hit || expired;
	assign tries_last = (33'(tries_q) + 33'd1) == tries_max;

	assign rem_sh = {rem_q, dvd_q[32]};
	assign rem_next = (rem_sh >= {1'b0, pool_size}) ? 33'(rem_sh - {1'b0, pool_size}) : rem_sh[32:0];
	assign div_last = div_cnt_q == 6'd32;

	assign free_hit = !valid_q[scan_idx_q];
	assign free_last = scan_idx_q == LAST_IDX;

	always_comb begin
		rq_commit = 1'b0;
		rq_refresh = 1'b0;
		rq_status = dlt_pkg::STS_OK;
		if (req_q.has_server_id) begin
			if (req_q.server_id_len != dlt_pkg::OPT_ADDR_LEN || req_q.server_id != server_q) begin
				rq_status = dlt_pkg::STS_OTHER_SERVER;
			end else if (!hit_q) begin
				rq_status = dlt_pkg::STS_UNKNOWN;
			end else begin
				rq_commit = 1'b1;
			end
		end else if (req_q.has_requested_ip) begin
			if (req_q.requested_ip_len != dlt_pkg::OPT_ADDR_LEN) begin
				rq_status = dlt_pkg::STS_BAD_OPTION;
			end else if (!hit_q) begin
				rq_status = dlt_pkg::STS_UNKNOWN;
			end else if (req_q.requested_ip != hit_ent_q.addr) begin
				rq_status = dlt_pkg::STS_MISMATCH;
			end else begin
				rq_refresh = 1'b1;
			end
		end else if (!hit_q) begin
			rq_status = dlt_pkg::STS_UNKNOWN;
		end else begin
			rq_refresh = 1'b1;
		end
	end

	always_comb begin
		dec_ent = hit_ent_q;
		dec_rsp = rsp_q;
		dec_dcl = 1'b0;
		unique case (req_q.func)
			dlt_pkg::FN_DISCOVER: begin
				if (hit_q) begin
					dec_ent.committed = 1'b0;
					dec_ent.granted_at = req_q.now_seconds;
					dec_ent.expires_at = req_q.now_seconds + lease_q;
					dec_rsp.reply = dlt_pkg::RPL_OFFER;
					dec_rsp.your_addr = hit_ent_q.addr;
					dec_rsp.lease_time = lease_q;
				end
			end
			dlt_pkg::FN_REQUEST: begin
				dec_rsp.status = rq_status;
				if (rq_commit) begin
					dec_ent.committed = 1'b1;
					dec_rsp.reply = dlt_pkg::RPL_ACK;
					dec_rsp.your_addr = hit_ent_q.addr;
					dec_rsp.lease_time = hit_ent_q.expires_at - hit_ent_q.granted_at;
				end else if (rq_refresh) begin
					dec_ent.granted_at = req_q.now_seconds;
					dec_ent.expires_at = req_q.now_seconds + lease_q;
					dec_rsp.reply = dlt_pkg::RPL_ACK;
					dec_rsp.your_addr = hit_ent_q.addr;
					dec_rsp.lease_time = lease_q;
				end
			end
			dlt_pkg::FN_RELEASE, dlt_pkg::FN_DECLINE: begin
				if (!hit_q) begin
					dec_rsp.status = dlt_pkg::STS_UNKNOWN;
				end
				dec_dcl = req_q.func == dlt_pkg::FN_DECLINE;
			end
			default: begin
				if (hit_q) begin
					dec_rsp.reply = dlt_pkg::RPL_ACK;
				end else begin
					dec_rsp.status = dlt_pkg::STS_UNKNOWN;
				end
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (func_bad || bad_len) ? dlt_pkg::ST_DONE : dlt_pkg::ST_CSCAN;
				end
			end
			dlt_pkg::ST_CSCAN: begin
				if (cscan_end) begin
					state_d = dlt_pkg::ST_DECIDE;
				end
			end
			dlt_pkg::ST_DECIDE: begin
				unique case (req_q.func)
					dlt_pkg::FN_DISCOVER: state_d = hit_q ? dlt_pkg::ST_WRITE : dlt_pkg::ST_DIV;
					dlt_pkg::FN_REQUEST:
						state_d = (rq_commit || rq_refresh) ? dlt_pkg::ST_WRITE : dlt_pkg::ST_DONE;
					dlt_pkg::FN_DECLINE: state_d = dlt_pkg::ST_DIV;
					default: state_d = dlt_pkg::ST_DONE;
				endcase
			end
			dlt_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = dcl_q ? dlt_pkg::ST_DONE : dlt_pkg::ST_HSCAN;
				end
			end
			dlt_pkg::ST_HSCAN: begin
				if (hscan_end) begin
					if (h_found) begin
						state_d = dlt_pkg::ST_FREE;
					end else if (tries_last) begin
						state_d = dlt_pkg::ST_DONE;
					end
				end
			end
			dlt_pkg::ST_FREE: begin
				if (free_hit) begin
					state_d = dlt_pkg::ST_WRITE;
				end else if (free_last) begin
					state_d = dlt_pkg::ST_DONE;
				end
			end
			dlt_pkg::ST_WRITE: state_d = dlt_pkg::ST_DONE;
			dlt_pkg::ST_DONE: state_d = dlt_pkg::ST_IDLE;
			default: state_d = dlt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != dlt_pkg::ST_IDLE;
		done = state_q == dlt_pkg::ST_DONE;
		mem_we = state_q == dlt_pkg::ST_WRITE;
	end

	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlt_pkg::ST_IDLE;
			first_q <= '0;
			last_q <= '0;
			server_q <= '0;
			lease_q <= dlt_pkg::LEASE_SEC_DEF;
			grace_q <= dlt_pkg::GRACE_SEC_DEF;
			valid_q <= '0;
			offset_q <= '0;
			iss_q <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					dlt_pkg::CFG_POOL_FIRST: first_q <= cfg_wdata;
					dlt_pkg::CFG_POOL_LAST: last_q <= cfg_wdata;
					dlt_pkg::CFG_SERVER: server_q <= cfg_wdata;
					dlt_pkg::CFG_LEASE: lease_q <= cfg_wdata;
					dlt_pkg::CFG_GRACE: grace_q <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (state_q)
				dlt_pkg::ST_IDLE: begin
					iss_q <= 1'b1;
					chk_vld_s1 <= 1'b0;
				end
				dlt_pkg::ST_CSCAN: begin
					chk_vld_s1 <= iss_q;
					if (iss_q && scan_idx_q == LAST_IDX) begin
						iss_q <= 1'b0;
					end
				end
				dlt_pkg::ST_DECIDE: begin
					if (hit_q && (req_q.func == dlt_pkg::FN_RELEASE ||
							req_q.func == dlt_pkg::FN_DECLINE)) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
				end
				dlt_pkg::ST_DIV: begin
					iss_q <= 1'b1;
					chk_vld_s1 <= 1'b0;
					if (div_last && dcl_q) begin
						offset_q <= rem_next[31:0];
					end
				end
				dlt_pkg::ST_HSCAN: begin
					if (hscan_end && !(h_found || tries_last)) begin
						iss_q <= 1'b1;
						chk_vld_s1 <= 1'b0;
					end else begin
						chk_vld_s1 <= iss_q;
						if (iss_q && scan_idx_q == LAST_IDX) begin
							iss_q <= 1'b0;
						end
					end
					if (hscan_end) begin
						if (hold_hit && expired) begin
							valid_q[chk_idx_s1] <= 1'b0;
						end
						if (h_found || tries_last) begin
							offset_q <= off_next;
						end
					end
				end
				dlt_pkg::ST_WRITE: begin
					if (ins_q) begin
						valid_q[wr_idx_q] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx_q] <= wr_ent_q;
		end
		mem_rd_s1 <= mem[scan_idx_q];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			dlt_pkg::ST_IDLE: begin
				if (accept) begin
					req_q <= req;
					key_q <= req.client_key & dlt_pkg::key_mask(req.key_len);
					rsp_q <= {dlt_pkg::RPL_NONE, 32'd0, 32'd0,
						(!func_bad && bad_len) ? dlt_pkg::STS_BAD_OPTION : dlt_pkg::STS_OK};
					hit_q <= 1'b0;
					scan_idx_q <= '0;
				end
			end
			dlt_pkg::ST_CSCAN: begin
				chk_idx_s1 <= scan_idx_q;
				if (iss_q && scan_idx_q != LAST_IDX) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (cli_hit) begin
					hit_q <= 1'b1;
					hit_idx_q <= chk_idx_s1;
					hit_ent_q <= mem_rd_s1;
				end
			end
			dlt_pkg::ST_DECIDE: begin
				wr_idx_q <= hit_idx_q;
				ins_q <= 1'b0;
				wr_ent_q <= dec_ent;
				rsp_q <= dec_rsp;
				rem_q <= '0;
				div_cnt_q <= '0;
				dvd_q <= dec_dcl ? ({1'b0, offset_q} + 33'd1) : {1'b0, offset_q};
				dcl_q <= dec_dcl;
			end
			dlt_pkg::ST_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[31:0], 1'b0};
				div_cnt_q <= div_cnt_q + 6'd1;
				if (div_last) begin
					off_q <= rem_next[31:0];
					tries_q <= '0;
					scan_idx_q <= '0;
				end
			end
			dlt_pkg::ST_HSCAN: begin
				chk_idx_s1 <= scan_idx_q;
				if (hscan_end) begin
					off_q <= off_next;
					scan_idx_q <= '0;
					if (h_found) begin
						cand_q <= cand;
					end else if (tries_last) begin
						rsp_q.status <= dlt_pkg::STS_EXHAUSTED;
					end else begin
						tries_q <= tries_q + 1'b1;
					end
				end else if (iss_q && scan_idx_q != LAST_IDX) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			dlt_pkg::ST_FREE: begin
				if (free_hit) begin
					wr_idx_q <= scan_idx_q;
					ins_q <= 1'b1;
					wr_ent_q <= {key_q, req_q.key_len, cand_q, 1'b0, req_q.now_seconds,
						req_q.now_seconds + lease_q};
					rsp_q <= {dlt_pkg::RPL_OFFER, cand_q, lease_q, dlt_pkg::STS_OK};
				end else if (free_last) begin
					rsp_q.status <= dlt_pkg::STS_TABLE_FULL;
				end else begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("done not followed by idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("accepted request did not raise busy");
	a_reply_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.reply != dlt_pkg::RPL_NONE |-> rsp.status == dlt_pkg::STS_OK)
		else $error("reply with non-ok status");
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> done)
		else $error("table write not followed by result");

endmodule

@@ tb/dhcp_lease_table_checker.sv @@
// Checker: predicts every lease table response and compares it with the block's output.
`timescale 1ns / 1ps
module dhcp_lease_table_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [31:0]   cfg_wdata,
	input  logic          start,
	input  logic          busy,
	input  dlt_pkg::req_t req,
	input  logic          done,
	input  dlt_pkg::rsp_t rsp,
	output int            errors,
	output int            pending
);

	localparam int NE = dlt_pkg::TABLE_ENTRIES_DEF;

	logic [31:0] first_addr, last_addr, srv_addr, lease_len, grace_len;
	logic        tv [NE];
	logic [63:0] tkey [NE];
	logic [3:0]  tlen [NE];
	logic [31:0] taddr [NE];
	logic        tcommit [NE];
	logic [31:0] tstart [NE];
	logic [31:0] tend [NE];
	logic [31:0] host_off;
	dlt_pkg::rsp_t replies_due [$];

	function automatic int find_client(logic [63:0] k, logic [3:0] l);
		for (int i = 0; i < NE; i++)
			if (tv[i] && tlen[i] == l && tkey[i] == k) return i;
		return -1;
	endfunction

	function automatic int find_holder(logic [31:0] a);
		for (int i = 0; i < NE; i++)
			if (tv[i] && taddr[i] == a) return i;
		return -1;
	endfunction

	function automatic dlt_pkg::rsp_t lease_decision(dlt_pkg::req_t r);
		dlt_pkg::rsp_t o;
		logic [63:0] k, m;
		logic [63:0] size, off, tries;
		logic [31:0] cand;
		int e, h;
		logic found;
		o = '0;
		e = -1;
		if (r.func > dlt_pkg::FN_INFORM) return o;
		if (r.key_len == 0 || r.key_len > dlt_pkg::KEY_BYTES) begin
			o.status = dlt_pkg::STS_BAD_OPTION;
			return o;
		end
		m = '0;
		for (int b = 0; b < 8; b++) if (b < r.key_len) m[8*b +: 8] = 8'hFF;
		k = r.client_key & m;
		e = find_client(k, r.key_len);
		size = 64'(32'(last_addr - first_addr)) + 1;
		case (r.func)
			dlt_pkg::FN_DISCOVER: begin
				if (e < 0) begin
					off = 64'(host_off) % size;
					tries = (size < NE + 1) ? size : NE + 1;
					found = 0;
					cand = 0;
					for (longint t = 0; t < tries; t++) begin
						cand = first_addr + off[31:0];
						h = find_holder(cand);
						if (h < 0) found = 1;
						else if (64'(r.now_seconds) > 64'(tend[h]) + 64'(grace_len)) begin
							tv[h] = 0;
							found = 1;
						end
						if (found) break;
						off = (off + 1) % size;
					end
					if (found) off = (off + 1) % size;
					host_off = off[31:0];
					if (!found) o.status = dlt_pkg::STS_EXHAUSTED;
					else begin
						for (int i = 0; i < NE; i++)
							if (!tv[i]) begin
								e = i;
								break;
							end
						if (e < 0) o.status = dlt_pkg::STS_TABLE_FULL;
						else begin
							tv[e] = 1;
							tkey[e] = k;
							tlen[e] = r.key_len;
							taddr[e] = cand;
						end
					end
				end
				if (e >= 0) begin
					tcommit[e] = 0;
					tstart[e] = r.now_seconds;
					tend[e] = r.now_seconds + lease_len;
					o.reply = dlt_pkg::RPL_OFFER;
				end
			end
			dlt_pkg::FN_REQUEST: begin
				if (r.has_server_id) begin
					if (r.server_id_len != dlt_pkg::OPT_ADDR_LEN || r.server_id != srv_addr)
						o.status = dlt_pkg::STS_OTHER_SERVER;
					else if (e < 0) o.status = dlt_pkg::STS_UNKNOWN;
					else begin
						tcommit[e] = 1;
						o.reply = dlt_pkg::RPL_ACK;
					end
				end else if (r.has_requested_ip) begin
					if (r.requested_ip_len != dlt_pkg::OPT_ADDR_LEN)
						o.status = dlt_pkg::STS_BAD_OPTION;
					else if (e < 0) o.status = dlt_pkg::STS_UNKNOWN;
					else if (r.requested_ip != taddr[e]) o.status = dlt_pkg::STS_MISMATCH;
					else begin
						tstart[e] = r.now_seconds;
						tend[e] = r.now_seconds + lease_len;
						o.reply = dlt_pkg::RPL_ACK;
					end
				end else if (e < 0) o.status = dlt_pkg::STS_UNKNOWN;
				else begin
					tstart[e] = r.now_seconds;
					tend[e] = r.now_seconds + lease_len;
					o.reply = dlt_pkg::RPL_ACK;
				end
			end
			dlt_pkg::FN_RELEASE, dlt_pkg::FN_DECLINE: begin
				if (e < 0) o.status = dlt_pkg::STS_UNKNOWN;
				else tv[e] = 0;
				if (r.func == dlt_pkg::FN_DECLINE)
					host_off = 32'((64'(host_off) + 1) % size);
			end
			default: begin
				if (e < 0) o.status = dlt_pkg::STS_UNKNOWN;
				else o.reply = dlt_pkg::RPL_ACK;
			end
		endcase
		if (o.reply != dlt_pkg::RPL_NONE && r.func != dlt_pkg::FN_INFORM && e >= 0) begin
			o.your_addr = taddr[e];
			o.lease_time = tend[e] - tstart[e];
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dlt_pkg::rsp_t w;
		if (!arst_n) begin
			first_addr <= 0;
			last_addr <= 0;
			srv_addr <= 0;
			lease_len <= dlt_pkg::LEASE_SEC_DEF;
			grace_len <= dlt_pkg::GRACE_SEC_DEF;
			for (int i = 0; i < NE; i++) tv[i] = 0;
			host_off = 0;
			errors = 0;
			replies_due.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) report_mismatch("unexpected response", 0, 0);
				else begin
					w = replies_due.pop_front();
					if (rsp.reply !== w.reply) report_mismatch("reply", rsp.reply, w.reply);
					if (rsp.your_addr !== w.your_addr)
						report_mismatch("your_addr", rsp.your_addr, w.your_addr);
					if (rsp.lease_time !== w.lease_time)
						report_mismatch("lease_time", rsp.lease_time, w.lease_time);
					if (rsp.status !== w.status) report_mismatch("status", rsp.status, w.status);
				end
			end
			if (start && !busy) replies_due.push_back(lease_decision(req));
			pending = replies_due.size();
			if (cfg_we) begin
				case (cfg_idx)
					dlt_pkg::CFG_POOL_FIRST: first_addr <= cfg_wdata;
					dlt_pkg::CFG_POOL_LAST:  last_addr <= cfg_wdata;
					dlt_pkg::CFG_SERVER:     srv_addr <= cfg_wdata;
					dlt_pkg::CFG_LEASE:      lease_len <= cfg_wdata;
					dlt_pkg::CFG_GRACE:      grace_len <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

@@ tb/dhcp_lease_table_core_tb.sv @@
// Testbench top: drives lease requests and configuration, reports the verdict.
`timescale 1ns / 1ps
module dhcp_lease_table_core_tb;

	localparam int IDLE_LIMIT = 400000;

	logic          clk = 0;
	logic          arst_n = 0;
	logic          cfg_we = 0;
	logic [2:0]    cfg_idx = '0;
	logic [31:0]   cfg_wdata = '0;
	logic          start = 0;
	dlt_pkg::req_t req = '0;
	logic          busy, done;
	dlt_pkg::rsp_t rsp;
	int            errors, pending;
	int            quiet_cycles = 0;
	logic [63:0]   client_keys [16];
	logic [31:0]   clock_now = 0;

	always #5 clk = ~clk;

	dhcp_lease_table_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .start(start), .req(req), .busy(busy),
		.done(done), .rsp(rsp)
	);

	dhcp_lease_table_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic settle();
		while (pending != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic send_request(dlt_pkg::req_t r);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
		repeat (gap) @(negedge clk);
		start <= 1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		start <= 0;
	endtask

	function automatic dlt_pkg::req_t lease_request(logic [2:0] f, int who);
		dlt_pkg::req_t r;
		r.func = f;
		r.client_key = client_keys[who];
		r.key_len = (who % 3 == 0) ? 4'd6 : 4'($urandom_range(1, 8));
		if (who % 3 != 0) r.key_len = 4'd8;
		clock_now = clock_now + $urandom_range(0, 40000);
		r.now_seconds = clock_now;
		r.has_server_id = ($urandom_range(0, 2) == 0);
		r.server_id_len = ($urandom_range(0, 7) == 0) ? 8'($urandom) : dlt_pkg::OPT_ADDR_LEN;
		r.server_id = ($urandom_range(0, 5) == 0) ? $urandom : 32'hC0A80001;
		r.has_requested_ip = $urandom_range(0, 1);
		r.requested_ip_len = ($urandom_range(0, 7) == 0) ? 8'($urandom) : dlt_pkg::OPT_ADDR_LEN;
		r.requested_ip = 32'hC0A80010 + $urandom_range(0, 12);
		return r;
	endfunction

	function automatic dlt_pkg::req_t noise_request();
		dlt_pkg::req_t r;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(dlt_pkg::req_t)-1:0];
		if ($urandom_range(0, 1)) r.func = 3'($urandom_range(0, 4));
		return r;
	endfunction

	initial begin
		dlt_pkg::req_t r;
		for (int i = 0; i < 16; i++) client_keys[i] = {$urandom, $urandom};
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		r = lease_request(dlt_pkg::FN_DISCOVER, 0);
		send_request(r);
		r.key_len = 0;
		send_request(r);
		r.key_len = 4'd9;
		send_request(r);
		r.key_len = 4'd15;
		send_request(r);
		r.func = 3'd7;
		send_request(r);
		r.func = 3'd5;
		send_request(r);
		settle();

		write_reg(dlt_pkg::CFG_POOL_FIRST, 32'hC0A80010);
		write_reg(dlt_pkg::CFG_POOL_LAST, 32'hC0A80013);
		write_reg(dlt_pkg::CFG_SERVER, 32'hC0A80001);
		write_reg(dlt_pkg::CFG_LEASE, 32'd100);
		write_reg(dlt_pkg::CFG_GRACE, 32'd0);
		for (int w = 0; w < 6; w++) send_request(lease_request(dlt_pkg::FN_DISCOVER, w));
		r = lease_request(dlt_pkg::FN_REQUEST, 1);
		r.has_server_id = 1; r.server_id_len = dlt_pkg::OPT_ADDR_LEN; r.server_id = 32'hC0A80001;
		send_request(r);
		r.server_id = 32'hC0A80002;
		send_request(r);
		r.has_server_id = 0; r.has_requested_ip = 1; r.requested_ip_len = 8'd5;
		send_request(r);
		r.requested_ip_len = dlt_pkg::OPT_ADDR_LEN; r.requested_ip = 32'hFFFFFFFF;
		send_request(r);
		r.has_requested_ip = 0;
		send_request(r);
		send_request(lease_request(dlt_pkg::FN_INFORM, 2));
		send_request(lease_request(dlt_pkg::FN_INFORM, 9));
		send_request(lease_request(dlt_pkg::FN_RELEASE, 2));
		send_request(lease_request(dlt_pkg::FN_DECLINE, 3));
		send_request(lease_request(dlt_pkg::FN_DECLINE, 11));
		r = lease_request(dlt_pkg::FN_DISCOVER, 12);
		r.client_key = '1; r.now_seconds = '1;
		send_request(r);
		settle();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(dlt_pkg::CFG_POOL_FIRST, 32'hC0A80010);
					write_reg(dlt_pkg::CFG_POOL_LAST, 32'hC0A8001C);
					write_reg(dlt_pkg::CFG_LEASE, 32'd50000);
					write_reg(dlt_pkg::CFG_GRACE, 32'd1000);
				end
				1: begin
					write_reg(dlt_pkg::CFG_POOL_FIRST, 32'hFFFFFFFE);
					write_reg(dlt_pkg::CFG_POOL_LAST, 32'h00000003);
					write_reg(dlt_pkg::CFG_LEASE, 32'd1);
					write_reg(dlt_pkg::CFG_GRACE, 32'hFFFFFFFF);
				end
				2: begin
					write_reg(dlt_pkg::CFG_POOL_FIRST, 32'h0A000000);
					write_reg(dlt_pkg::CFG_POOL_LAST, 32'h0A000000);
					write_reg(dlt_pkg::CFG_LEASE, 32'hFFFFFFFF);
					write_reg(dlt_pkg::CFG_GRACE, 32'd0);
				end
				3: begin
					write_reg(dlt_pkg::CFG_POOL_FIRST, 32'h00000000);
					write_reg(dlt_pkg::CFG_POOL_LAST, 32'hFFFFFFFF);
					write_reg(dlt_pkg::CFG_SERVER, 32'hFFFFFFFF);
					write_reg(dlt_pkg::CFG_LEASE, 32'd20000);
				end
				default: begin
					write_reg(dlt_pkg::CFG_POOL_FIRST, 32'hC0A80010);
					write_reg(dlt_pkg::CFG_POOL_LAST, 32'hC0A80017);
					write_reg(dlt_pkg::CFG_SERVER, 32'hC0A80001);
					write_reg(dlt_pkg::CFG_LEASE, 32'd30000);
					write_reg(dlt_pkg::CFG_GRACE, 32'd5000);
				end
			endcase
			for (int n = 0; n < 150; n++) begin
				if ($urandom_range(0, 9) == 0) r = noise_request();
				else r = lease_request(3'($urandom_range(0, 4)), $urandom_range(0, 15));
				if (r.func == dlt_pkg::FN_REQUEST && $urandom_range(0, 2) == 0)
					r.server_id = 32'hFFFFFFFF;
				send_request(r);
			end
			settle();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
